[rtl/lsl_pkg.sv]
// ----------------------------------------------------------------------------
// Light sensor lux calculator: shared package
// Constants, coefficient tables, configuration codes and the types that pass
// between the front end, the classified-item queue and the back end.
// ----------------------------------------------------------------------------
package lsl_pkg;

  // Fixed-point scales of the lux calculation.
  localparam int LUX_SHIFT   = 14;
  localparam int CH_SHIFT    = 10;
  localparam int RATIO_SHIFT = 9;

  // Field widths.
  localparam int COUNT_W = 16;
  localparam int LUX_W   = 17;
  localparam int ITIME_W = 2;

  // Configuration register indexes (byte address is four times the index).
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int REG_W   = 2;
  typedef enum logic [REG_W-1:0] {
    REG_ITIME   = 2'd0,
    REG_GAIN    = 2'd1,
    REG_PACKAGE = 2'd2
  } cfg_reg_e;

  // Integration time codes; the unused code behaves as the longest time.
  localparam logic [ITIME_W-1:0] ITIME_13MS  = ITIME_W'(0);
  localparam logic [ITIME_W-1:0] ITIME_101MS = ITIME_W'(1);
  localparam logic [ITIME_W-1:0] ITIME_402MS = ITIME_W'(2);

  // Clipping thresholds: a count strictly above the threshold saturates.
  localparam logic [COUNT_W-1:0] CLIP_13MS  = COUNT_W'(4900);
  localparam logic [COUNT_W-1:0] CLIP_101MS = COUNT_W'(37000);
  localparam logic [COUNT_W-1:0] CLIP_402MS = COUNT_W'(65000);

  // Channel scales to the 402 ms basis, rounded, in CH_SHIFT fixed point.
  localparam int unsigned SCALE_13MS  = (((322 << (CH_SHIFT + 1)) / 11) + 1) >> 1;
  localparam int unsigned SCALE_101MS = (((322 << (CH_SHIFT + 1)) / 81) + 1) >> 1;
  localparam int unsigned SCALE_402MS = 1 << CH_SHIFT;
  localparam int GAIN_SHIFT = 4;
  localparam int SCALE_W    = CH_SHIFT + 9;

  // A scaled channel stays below 2^22 whenever the counts are not clipped.
  localparam int CH_W = 22;

  // Coefficient tables: eight segments, two packages.
  localparam int TAB_W = 10;
  localparam int NSEG  = 8;
  localparam int SEG_W = 3;
  localparam logic [TAB_W-1:0] KNEE_TAB [2][NSEG] = '{
    '{10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a, 10'h29a},
    '{10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a, 10'h29a}
  };
  localparam logic [TAB_W-1:0] OFF_TAB [2][NSEG] = '{
    '{10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000},
    '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037, 10'h000}
  };
  localparam logic [TAB_W-1:0] SLOPE_TAB [2][NSEG] = '{
    '{10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000},
    '{10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b, 10'h000}
  };

  // The quotient is held one bit wider than a knee, so that a capped value
  // lies beyond every breakpoint.
  localparam int Q_W     = TAB_W + 1;
  localparam int NUM_W   = CH_W + RATIO_SHIFT + 1;
  localparam int DIV_W   = (NUM_W > CH_W + Q_W) ? NUM_W : CH_W + Q_W;
  localparam int PROD_W  = CH_W + TAB_W;

  localparam logic [LUX_W-1:0] SAT_LUX = LUX_W'(65536);
  localparam logic [LUX_W-1:0] MAX_LUX = LUX_W'(65535);

  // Classified-item queue between front and back end (depth a power of two).
  localparam int MQ_DEPTH = 4;
  localparam int MQ_AW    = 2;

  typedef struct packed {
    logic [ITIME_W-1:0] itime;
    logic               gain_high;
    logic               package_cs;
  } cfg_t;

  typedef struct packed {
    logic            sat;
    logic            tab;
    logic [CH_W-1:0] ch0;
    logic [CH_W-1:0] ch1;
  } mid_item_t;

  function automatic logic [COUNT_W-1:0] clip_of(input logic [ITIME_W-1:0] itime);
    logic [COUNT_W-1:0] c;
    case (itime)
      ITIME_13MS:  c = CLIP_13MS;
      ITIME_101MS: c = CLIP_101MS;
      default:     c = CLIP_402MS;
    endcase
    return c;
  endfunction

  function automatic logic [SCALE_W-1:0] scale_of(input logic [ITIME_W-1:0] itime,
                                                  input logic gain_high);
    logic [SCALE_W-1:0] s;
    case (itime)
      ITIME_13MS:  s = SCALE_W'(SCALE_13MS);
      ITIME_101MS: s = SCALE_W'(SCALE_101MS);
      default:     s = SCALE_W'(SCALE_402MS);
    endcase
    if (!gain_high) begin
      s = s << GAIN_SHIFT;
    end
    return s;
  endfunction

endpackage

[rtl/lsl_queue.sv]
// ----------------------------------------------------------------------------
// Classified-item queue
// A short first-in first-out buffer that lets the front and back end stall
// independently of each other.
// ----------------------------------------------------------------------------
module lsl_queue
  import lsl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  mid_item_t wdata,
  output logic      full,
  input  logic      pop,
  output mid_item_t rdata,
  output logic      empty
);

  mid_item_t        mem_r [MQ_DEPTH];
  logic [MQ_AW-1:0] wr_ptr_r;
  logic [MQ_AW-1:0] rd_ptr_r;
  logic [MQ_AW:0]   cnt_r;
  logic [MQ_AW:0]   cnt_nxt;

  assign full  = (cnt_r == (MQ_AW + 1)'(MQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (MQ_AW + 1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (MQ_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + MQ_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + MQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("classified-item queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("classified-item queue read while empty");
`endif

endmodule

[rtl/lsl_front.sv]
// ----------------------------------------------------------------------------
// Front end
// Takes a reading pair, checks it against the clipping threshold and scales
// both channels to the common basis, then hands the item to the queue.
// ----------------------------------------------------------------------------
module lsl_front
  import lsl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               push,
  input  logic [COUNT_W-1:0] broadband_count,
  input  logic [COUNT_W-1:0] infrared_count,
  output logic               full,
  output logic               q_push,
  output mid_item_t          q_wdata,
  input  logic               q_full
);

  localparam int PRE_W = COUNT_W + SCALE_W;

  logic               vld_r;
  mid_item_t          item_r;
  mid_item_t          item_nxt;
  logic               load;
  logic [COUNT_W-1:0] clip;
  logic [SCALE_W-1:0] scale;
  logic [PRE_W-1:0]   prod0;
  logic [PRE_W-1:0]   prod1;

  // The stage register takes a new item when it is empty or its item moves on.
  assign load    = !vld_r || !q_full;
  assign full    = !load;
  assign q_push  = vld_r && !q_full;
  assign q_wdata = item_r;

  always_comb begin
    clip  = clip_of(cfg.itime);
    scale = scale_of(cfg.itime, cfg.gain_high);
    prod0 = PRE_W'(broadband_count) * PRE_W'(scale);
    prod1 = PRE_W'(infrared_count) * PRE_W'(scale);
    item_nxt.sat = (broadband_count > clip) || (infrared_count > clip);
    item_nxt.tab = cfg.package_cs;
    item_nxt.ch0 = prod0[CH_SHIFT +: CH_W];
    item_nxt.ch1 = prod1[CH_SHIFT +: CH_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && load) begin
      item_r <= item_nxt;
    end
  end

endmodule

[rtl/lsl_back.sv]
// ----------------------------------------------------------------------------
// Back end
// Pipelined ratio divider, segment selection, coefficient products, rounding
// and the result queue. The whole pipeline advances while the result queue
// has room.
// ----------------------------------------------------------------------------
module lsl_back
  import lsl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  mid_item_t        q_rdata,
  input  logic             q_empty,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [LUX_W-1:0] lux_value,
  output logic             saturated
);

  localparam int DS       = Q_W + 1;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [Q_W-1:0]   quo;
    logic             done;
    logic             sat;
    logic             tab;
    logic [CH_W-1:0]  ch0;
    logic [CH_W-1:0]  ch1;
  } div_st_t;

  typedef struct packed {
    logic             sat;
    logic [CH_W-1:0]  ch0;
    logic [CH_W-1:0]  ch1;
    logic [TAB_W-1:0] off;
    logic [TAB_W-1:0] slope;
  } seg_st_t;

  typedef struct packed {
    logic              sat;
    logic [PROD_W-1:0] p0;
    logic [PROD_W-1:0] p1;
  } mul_st_t;

  typedef struct packed {
    logic [LUX_W-1:0] lux;
    logic             sat;
  } out_item_t;

  logic              en;
  logic              take;
  div_st_t           ent;
  div_st_t           st_r   [DS];
  div_st_t           st_nxt [DS];
  logic [DS-1:0]     st_vld_r;
  seg_st_t           seg_r;
  seg_st_t           seg_nxt;
  logic              seg_vld_r;
  mul_st_t           mul_r;
  logic              mul_vld_r;
  logic              dif_sat_r;
  logic [PROD_W-1:0] dif_r;
  logic              dif_vld_r;
  logic [Q_W:0]      q_plus1;
  logic [Q_W-1:0]    ratio;
  logic [SEG_W-1:0]  seg;
  logic [PROD_W:0]   acc;
  logic [PROD_W:0]   acc_sh;
  out_item_t         res;
  out_item_t         oq_mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0]  oq_wp_r;
  logic [OQ_AW-1:0]  oq_rp_r;
  logic [OQ_AW:0]    oq_cnt_r;
  logic [OQ_AW:0]    oq_cnt_nxt;
  logic              oq_push;
  logic              oq_pop;

  assign en    = (oq_cnt_r != (OQ_AW + 1)'(OQ_DEPTH));
  assign take  = en && !q_empty;
  assign q_pop = take;

  always_comb begin
    ent      = '0;
    ent.rem  = DIV_W'(q_rdata.ch1) << (RATIO_SHIFT + 1);
    ent.sat  = q_rdata.sat;
    ent.tab  = q_rdata.tab;
    ent.ch0  = q_rdata.ch0;
    ent.ch1  = q_rdata.ch1;
  end

  // Restoring division, one quotient bit per stage. The first stage only
  // finds a zero divisor or an overflowing quotient; the latter is capped.
  for (genvar g = 0; g < DS; g++) begin : g_div
    if (g == 0) begin : g_first
      always_comb begin
        st_nxt[g] = ent;
        if (ent.ch0 == '0) begin
          st_nxt[g].done = 1'b1;
        end else if (ent.rem >= (DIV_W'(ent.ch0) << Q_W)) begin
          st_nxt[g].done = 1'b1;
          st_nxt[g].quo  = '1;
        end
      end
    end else begin : g_bit
      localparam int B = Q_W - g;
      logic [DIV_W-1:0] dsh;
      always_comb begin
        dsh       = DIV_W'(st_r[g-1].ch0) << B;
        st_nxt[g] = st_r[g-1];
        if (!st_r[g-1].done && (st_r[g-1].rem >= dsh)) begin
          st_nxt[g].rem    = st_r[g-1].rem - dsh;
          st_nxt[g].quo[B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g] <= st_nxt[g];
      end
    end
  end

  // Rounded ratio and the first segment whose knee it does not exceed.
  always_comb begin
    q_plus1 = {1'b0, st_r[DS-1].quo} + (Q_W + 1)'(1);
    ratio   = q_plus1[Q_W:1];
    seg     = SEG_W'(NSEG - 1);
    for (int i = NSEG - 2; i >= 0; i--) begin
      if (ratio <= Q_W'(KNEE_TAB[st_r[DS-1].tab][i])) begin
        seg = SEG_W'(i);
      end
    end
    seg_nxt.sat   = st_r[DS-1].sat;
    seg_nxt.ch0   = st_r[DS-1].ch0;
    seg_nxt.ch1   = st_r[DS-1].ch1;
    seg_nxt.off   = OFF_TAB[st_r[DS-1].tab][seg];
    seg_nxt.slope = SLOPE_TAB[st_r[DS-1].tab][seg];
  end

  // Round, shift and clamp; a saturated item overrides the value.
  always_comb begin
    acc    = {1'b0, dif_r} + ((PROD_W + 1)'(1) << (LUX_SHIFT - 1));
    acc_sh = acc >> LUX_SHIFT;
    res.sat = dif_sat_r;
    if (dif_sat_r) begin
      res.lux = SAT_LUX;
    end else if (acc_sh > (PROD_W + 1)'(MAX_LUX)) begin
      res.lux = MAX_LUX;
    end else begin
      res.lux = acc_sh[LUX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r  <= '0;
      seg_vld_r <= 1'b0;
      mul_vld_r <= 1'b0;
      dif_vld_r <= 1'b0;
    end else if (en) begin
      st_vld_r  <= {st_vld_r[DS-2:0], take};
      seg_vld_r <= st_vld_r[DS-1];
      mul_vld_r <= seg_vld_r;
      dif_vld_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_r     <= seg_nxt;
      mul_r.sat <= seg_r.sat;
      mul_r.p0  <= PROD_W'(seg_r.ch0) * PROD_W'(seg_r.off);
      mul_r.p1  <= PROD_W'(seg_r.ch1) * PROD_W'(seg_r.slope);
      dif_sat_r <= mul_r.sat;
      dif_r     <= (mul_r.p0 > mul_r.p1) ? (mul_r.p0 - mul_r.p1) : '0;
    end
  end

  // Result queue.
  assign oq_push   = en && dif_vld_r;
  assign empty     = (oq_cnt_r == '0);
  assign oq_pop    = pop && !empty;
  assign lux_value = oq_mem_r[oq_rp_r].lux;
  assign saturated = oq_mem_r[oq_rp_r].sat;

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (oq_push && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + (OQ_AW + 1)'(1);
    end else if (oq_pop && !oq_push) begin
      oq_cnt_nxt = oq_cnt_r - (OQ_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
      if (oq_push) begin
        oq_wp_r <= oq_wp_r + OQ_AW'(1);
      end
      if (oq_pop) begin
        oq_rp_r <= oq_rp_r + OQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_mem_r[oq_wp_r] <= res;
    end
  end

`ifndef SYNTHESIS
  a_oq_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= (OQ_AW + 1)'(OQ_DEPTH))
    else $error("result queue count beyond its depth");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && saturated) |-> (lux_value == SAT_LUX))
    else $error("saturated result without the saturation value");
`endif

endmodule

[rtl/light_sensor_lux_calc.sv]
// ----------------------------------------------------------------------------
// Light sensor lux calculator
// Turns a broadband and an infrared count into integer lux, with saturation
// detection, integration-time and gain scaling and a choice of two
// coefficient tables.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake          Payload
//   input     push / full        in_broadband_count, in_infrared_count
//   result    empty / pop        out_lux_value, out_saturated
//   config    psel/penable/...   paddr, pwdata, prdata (APB-style, ready tied)
//
// One reading is accepted per cycle while full is low, and each gives one
// result. The ratio divider resolves one quotient bit per pipeline stage.
// Reset clears the configuration registers and empties both queues; no
// clearing pass is needed.
// When the four-entry result queue is full the back end freezes, the
// classified-item queue fills and full rises on the input side.
//
// ----------------------------------------------------------------------------
module light_sensor_lux_calc
  import lsl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Input channel.
  input  logic               push,
  output logic               full,
  input  logic [COUNT_W-1:0] in_broadband_count,
  input  logic [COUNT_W-1:0] in_infrared_count,
  // Result channel.
  output logic               empty,
  input  logic               pop,
  output logic [LUX_W-1:0]   out_lux_value,
  output logic               out_saturated,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t      cfg_r;
  logic      cfg_wr;
  cfg_reg_e  cfg_idx;
  logic      mq_push;
  mid_item_t mq_wdata;
  logic      mq_full;
  logic      mq_pop;
  mid_item_t mq_rdata;
  logic      mq_empty;

  // The register file never waits, so pready is tied high.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_reg_e'(paddr[PADDR_W-1:2]);

  // Writes to addresses beyond the three registers are ignored. Only the low
  // bits of the written word that the register holds are kept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ITIME:   cfg_r.itime      <= pwdata[ITIME_W-1:0];
        REG_GAIN:    cfg_r.gain_high  <= pwdata[0];
        REG_PACKAGE: cfg_r.package_cs <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ITIME:   prdata = PDATA_W'(cfg_r.itime);
      REG_GAIN:    prdata = PDATA_W'(cfg_r.gain_high);
      REG_PACKAGE: prdata = PDATA_W'(cfg_r.package_cs);
      default:     prdata = '0;
    endcase
  end

  // The front end classifies and scales; the queue decouples it from the
  // long back-end pipeline.
  lsl_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .push            (push),
    .broadband_count (in_broadband_count),
    .infrared_count  (in_infrared_count),
    .full            (full),
    .q_push          (mq_push),
    .q_wdata         (mq_wdata),
    .q_full          (mq_full)
  );

  lsl_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .wdata (mq_wdata),
    .full  (mq_full),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .empty (mq_empty)
  );

  lsl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rdata   (mq_rdata),
    .q_empty   (mq_empty),
    .q_pop     (mq_pop),
    .pop       (pop),
    .empty     (empty),
    .lux_value (out_lux_value),
    .saturated (out_saturated)
  );

endmodule
